@@ sv/twce_pkg.sv @@
// ----------------------------------------------------------------------------
// twce_pkg: shared types and constants of the text-window cell engine
// Request and result payloads, controller/datapath command and status
// bundles, function codes, cursor and walk operation codes.
// ----------------------------------------------------------------------------
package twce_pkg;

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 64;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTRS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKED = 3'd4;

    localparam logic [7:0]  COLS_RST  = 8'd80;
    localparam logic [6:0]  ROWS_RST  = 7'd24;
    localparam logic [15:0] ATTRS_RST = 16'd0;
    localparam logic [20:0] BLANK_RST = 21'd32;

    // character codes
    localparam logic [20:0] CH_TAB = 21'h09;
    localparam logic [20:0] CH_CR  = 21'h0d;
    localparam logic [20:0] CH_LF  = 21'h0a;
    localparam logic [31:0] CONT_MARK = 32'hDEADC0DE;

    // function codes
    localparam logic [4:0] FN_EMIT         = 5'd0;
    localparam logic [4:0] FN_CR           = 5'd1;
    localparam logic [4:0] FN_CLEAR        = 5'd2;
    localparam logic [4:0] FN_CLEAR_LINE   = 5'd3;
    localparam logic [4:0] FN_SCROLL_UP    = 5'd4;
    localparam logic [4:0] FN_SCROLL_DOWN  = 5'd5;
    localparam logic [4:0] FN_SCROLL_LEFT  = 5'd6;
    localparam logic [4:0] FN_SCROLL_RIGHT = 5'd7;
    localparam logic [4:0] FN_SET_XY       = 5'd8;
    localparam logic [4:0] FN_SET_X        = 5'd9;
    localparam logic [4:0] FN_SET_Y        = 5'd10;
    localparam logic [4:0] FN_STEP_UP      = 5'd11;
    localparam logic [4:0] FN_STEP_DOWN    = 5'd12;
    localparam logic [4:0] FN_STEP_LEFT    = 5'd13;
    localparam logic [4:0] FN_STEP_RIGHT   = 5'd14;
    localparam logic [4:0] FN_PEEK         = 5'd15;
    localparam logic [4:0] FN_ERASE_EOL    = 5'd16;

    // cursor column operations
    localparam logic [2:0] CX_KEEP = 3'd0;
    localparam logic [2:0] CX_ZERO = 3'd1;
    localparam logic [2:0] CX_INC  = 3'd2;
    localparam logic [2:0] CX_DEC  = 3'd3;
    localparam logic [2:0] CX_LAST = 3'd4;
    localparam logic [2:0] CX_LOAD = 3'd5;

    // cursor row operations
    localparam logic [2:0] CY_KEEP = 3'd0;
    localparam logic [2:0] CY_ZERO = 3'd1;
    localparam logic [2:0] CY_INC  = 3'd2;
    localparam logic [2:0] CY_DEC  = 3'd3;
    localparam logic [2:0] CY_LOAD = 3'd4;

    // store walk kinds
    localparam logic [2:0] WK_UP    = 3'd0;
    localparam logic [2:0] WK_DOWN  = 3'd1;
    localparam logic [2:0] WK_LEFT  = 3'd2;
    localparam logic [2:0] WK_RIGHT = 3'd3;
    localparam logic [2:0] WK_CLEAR = 3'd4;
    localparam logic [2:0] WK_LINE  = 3'd5;

    typedef struct packed {
        logic [4:0]  func;
        logic [20:0] char_code;
        logic [2:0]  char_cols;
        logic [7:0]  amount;
        logic [6:0]  pos_col;
        logic [5:0]  pos_row;
    } in_item_t;

    typedef struct packed {
        logic [31:0] cell_code;
        logic [15:0] cell_attrs;
        logic        cell_valid;
        logic [6:0]  cursor_col;
        logic [5:0]  cursor_row;
    } out_item_t;

    typedef struct packed {
        logic       latch_req;
        logic       clamp;
        logic [2:0] cx_op;
        logic [2:0] cy_op;
        logic       walk_start;
        logic [2:0] walk_kind;
        logic       walk_one;
        logic       walk_rd;
        logic       walk_wr;
        logic       draw_init;
        logic       erase_init;
        logic       put;
        logic       next;
        logic       peek_rd;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [4:0] func;
        logic       is_tab;
        logic       is_eol;
        logic       w_zero;
        logic       fits;
        logic       cx_last;
        logic       cy_last;
        logic       cx_zero;
        logic       cy_zero;
        logic       locked;
        logic       col_ok;
        logic       row_ok;
        logic       amount_zero;
        logic       wcnt_one;
        logic       walk_last;
        logic       out_free;
    } status_t;

endpackage

@@ sv/twce_ctrl.sv @@
// ----------------------------------------------------------------------------
// twce_ctrl: command sequencer of the text-window cell engine
// Decodes each request and steps the datapath through cursor moves, cell
// writes, store walks and the result hand-off.
// ----------------------------------------------------------------------------
module twce_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  twce_pkg::status_t stat,
    output twce_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CLAMP  = 4'd1;
    localparam logic [3:0] ST_DECODE = 4'd2;
    localparam logic [3:0] ST_PUT    = 4'd3;
    localparam logic [3:0] ST_NEXT   = 4'd4;
    localparam logic [3:0] ST_SDOWN  = 4'd5;
    localparam logic [3:0] ST_WRD    = 4'd6;
    localparam logic [3:0] ST_WWR    = 4'd7;
    localparam logic [3:0] ST_FIN    = 4'd8;

    localparam logic [1:0] RET_FIN  = 2'd0;
    localparam logic [1:0] RET_NEXT = 2'd1;
    localparam logic [1:0] RET_PUT  = 2'd2;

    logic [3:0] state_reg, state_next;
    logic [1:0] ret_reg, ret_next;

    function automatic logic [3:0] ret_state(input logic [1:0] r);
        logic [3:0] s;
        case (r)
            RET_NEXT: s = ST_NEXT;
            RET_PUT:  s = ST_PUT;
            default:  s = ST_FIN;
        endcase
        return s;
    endfunction

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                state_next = ST_FIN;
                ret_next   = RET_FIN;
                case (stat.func)
                    twce_pkg::FN_EMIT:
                    begin
                        if (stat.is_tab || (!stat.is_eol && stat.w_zero))
                        begin
                            state_next = ST_FIN;
                        end
                        else if (stat.is_eol)
                        begin
                            cmd.cx_op  = twce_pkg::CX_ZERO;
                            state_next = ST_SDOWN;
                        end
                        else
                        begin
                            cmd.draw_init = 1'b1;
                            if (stat.fits)
                            begin
                                state_next = ST_PUT;
                            end
                            else
                            begin
                                cmd.cx_op  = twce_pkg::CX_ZERO;
                                ret_next   = RET_PUT;
                                state_next = ST_SDOWN;
                            end
                        end
                    end
                    twce_pkg::FN_CR:
                    begin
                        cmd.cx_op  = twce_pkg::CX_ZERO;
                        state_next = ST_SDOWN;
                    end
                    twce_pkg::FN_CLEAR:
                    begin
                        cmd.cx_op      = twce_pkg::CX_ZERO;
                        cmd.cy_op      = twce_pkg::CY_ZERO;
                        cmd.walk_start = 1'b1;
                        cmd.walk_kind  = twce_pkg::WK_CLEAR;
                        state_next     = ST_WRD;
                    end
                    twce_pkg::FN_CLEAR_LINE:
                    begin
                        if (stat.row_ok)
                        begin
                            cmd.walk_start = 1'b1;
                            cmd.walk_kind  = twce_pkg::WK_LINE;
                            state_next     = ST_WRD;
                        end
                    end
                    twce_pkg::FN_SCROLL_UP, twce_pkg::FN_SCROLL_DOWN,
                    twce_pkg::FN_SCROLL_LEFT, twce_pkg::FN_SCROLL_RIGHT:
                    begin
                        if (!stat.amount_zero)
                        begin
                            cmd.walk_start = 1'b1;
                            cmd.walk_kind  = 3'(stat.func - twce_pkg::FN_SCROLL_UP);
                            state_next     = ST_WRD;
                        end
                    end
                    twce_pkg::FN_SET_XY:
                    begin
                        if (stat.col_ok && stat.row_ok)
                        begin
                            cmd.cx_op = twce_pkg::CX_LOAD;
                            cmd.cy_op = twce_pkg::CY_LOAD;
                        end
                    end
                    twce_pkg::FN_SET_X:
                    begin
                        if (stat.col_ok)
                        begin
                            cmd.cx_op = twce_pkg::CX_LOAD;
                        end
                    end
                    twce_pkg::FN_SET_Y:
                    begin
                        if (stat.row_ok)
                        begin
                            cmd.cy_op = twce_pkg::CY_LOAD;
                        end
                    end
                    twce_pkg::FN_STEP_UP:
                    begin
                        if (!stat.cy_zero)
                        begin
                            cmd.cy_op = twce_pkg::CY_DEC;
                        end
                    end
                    twce_pkg::FN_STEP_DOWN:
                    begin
                        state_next = ST_SDOWN;
                    end
                    twce_pkg::FN_STEP_LEFT:
                    begin
                        if (!stat.cx_zero)
                        begin
                            cmd.cx_op = twce_pkg::CX_DEC;
                        end
                        else if (!stat.cy_zero)
                        begin
                            cmd.cy_op = twce_pkg::CY_DEC;
                            cmd.cx_op = twce_pkg::CX_LAST;
                        end
                    end
                    twce_pkg::FN_STEP_RIGHT:
                    begin
                        if (!stat.cx_last)
                        begin
                            cmd.cx_op = twce_pkg::CX_INC;
                        end
                        else
                        begin
                            cmd.cx_op = twce_pkg::CX_ZERO;
                            if (!stat.locked)
                            begin
                                state_next = ST_SDOWN;
                            end
                        end
                    end
                    twce_pkg::FN_PEEK:
                    begin
                        cmd.peek_rd = 1'b1;
                    end
                    twce_pkg::FN_ERASE_EOL:
                    begin
                        cmd.erase_init = 1'b1;
                        state_next     = ST_PUT;
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_PUT:
            begin
                // write the cell under the cursor, then step right
                cmd.put = 1'b1;
                if (!stat.cx_last)
                begin
                    cmd.cx_op  = twce_pkg::CX_INC;
                    state_next = ST_NEXT;
                end
                else
                begin
                    cmd.cx_op = twce_pkg::CX_ZERO;
                    if (stat.locked)
                    begin
                        state_next = ST_NEXT;
                    end
                    else
                    begin
                        ret_next   = RET_NEXT;
                        state_next = ST_SDOWN;
                    end
                end
            end
            ST_NEXT:
            begin
                if (stat.wcnt_one)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.next   = 1'b1;
                    state_next = ST_PUT;
                end
            end
            ST_SDOWN:
            begin
                if (!stat.cy_last)
                begin
                    cmd.cy_op  = twce_pkg::CY_INC;
                    state_next = ret_state(ret_reg);
                end
                else if (!stat.locked)
                begin
                    cmd.walk_start = 1'b1;
                    cmd.walk_kind  = twce_pkg::WK_UP;
                    cmd.walk_one   = 1'b1;
                    state_next     = ST_WRD;
                end
                else
                begin
                    state_next = ret_state(ret_reg);
                end
            end
            ST_WRD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = ST_WWR;
            end
            ST_WWR:
            begin
                cmd.walk_wr = 1'b1;
                state_next  = stat.walk_last ? ret_state(ret_reg) : ST_WRD;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= RET_FIN;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

@@ sv/twce_dpath.sv @@
// ----------------------------------------------------------------------------
// twce_dpath: datapath of the text-window cell engine
// Configuration, cursor, cell store, walk counters and result register.
// ----------------------------------------------------------------------------
module twce_dpath #(
    parameter int MAX_COLS = twce_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = twce_pkg::MAX_ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [twce_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [twce_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  twce_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output twce_pkg::out_item_t                 out_item,
    input  twce_pkg::cmd_t                      cmd,
    output twce_pkg::status_t                   stat
);

    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CIW   = $clog2(MAX_COLS);
    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int MW    = (CW > RW) ? CW : RW;
    localparam int KW    = ((MW > 8) ? MW : 8) + 1;
    localparam int WCW   = (CW > 3) ? CW : 3;
    localparam int PW    = RIW + CW;

    // configuration
    logic [7:0]  cols_reg;
    logic [6:0]  rows_reg;
    logic [15:0] attrs_reg;
    logic [20:0] blank_reg;
    logic        locked_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg   <= twce_pkg::COLS_RST;
            rows_reg   <= twce_pkg::ROWS_RST;
            attrs_reg  <= twce_pkg::ATTRS_RST;
            blank_reg  <= twce_pkg::BLANK_RST;
            locked_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                twce_pkg::CFG_COLS:   cols_reg   <= cfg_data[7:0];
                twce_pkg::CFG_ROWS:   rows_reg   <= cfg_data[6:0];
                twce_pkg::CFG_ATTRS:  attrs_reg  <= cfg_data[15:0];
                twce_pkg::CFG_BLANK:  blank_reg  <= cfg_data;
                twce_pkg::CFG_LOCKED: locked_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // saturate the window size to the store, a zero size counting as one
    logic [CW-1:0] cols_eff;
    logic [RW-1:0] rows_eff;

    always_comb
    begin
        if (cols_reg == 8'd0)
            cols_eff = CW'(1);
        else if (KW'(cols_reg) > KW'(MAX_COLS))
            cols_eff = CW'(MAX_COLS);
        else
            cols_eff = CW'(cols_reg);
        if (rows_reg == 7'd0)
            rows_eff = RW'(1);
        else if (KW'(rows_reg) > KW'(MAX_ROWS))
            rows_eff = RW'(MAX_ROWS);
        else
            rows_eff = RW'(rows_reg);
    end

    logic [KW-1:0] cols_k, rows_k;
    assign cols_k = KW'(cols_eff);
    assign rows_k = KW'(rows_eff);

    // request
    twce_pkg::in_item_t req_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
            req_reg <= in_item;
    end

    // cursor
    logic [CIW-1:0] cx_reg, cx_next;
    logic [RIW-1:0] cy_reg, cy_next;
    logic [CIW-1:0] cx_lastcol;
    logic [RIW-1:0] cy_lastrow;

    assign cx_lastcol = CIW'(cols_eff - CW'(1));
    assign cy_lastrow = RIW'(rows_eff - RW'(1));

    always_comb
    begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        if (cmd.clamp)
        begin
            if (KW'(cx_reg) >= cols_k)
                cx_next = cx_lastcol;
            if (KW'(cy_reg) >= rows_k)
                cy_next = cy_lastrow;
        end
        else
        begin
            case (cmd.cx_op)
                twce_pkg::CX_ZERO: cx_next = '0;
                twce_pkg::CX_INC:  cx_next = cx_reg + CIW'(1);
                twce_pkg::CX_DEC:  cx_next = cx_reg - CIW'(1);
                twce_pkg::CX_LAST: cx_next = cx_lastcol;
                twce_pkg::CX_LOAD: cx_next = CIW'(req_reg.pos_col);
                default:           cx_next = cx_reg;
            endcase
            case (cmd.cy_op)
                twce_pkg::CY_ZERO: cy_next = '0;
                twce_pkg::CY_INC:  cy_next = cy_reg + RIW'(1);
                twce_pkg::CY_DEC:  cy_next = cy_reg - RIW'(1);
                twce_pkg::CY_LOAD: cy_next = RIW'(req_reg.pos_row);
                default:           cy_next = cy_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
        end
    end

    // character drawing run
    logic [WCW-1:0] wcnt_reg;
    logic           first_reg;
    logic           erase_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.draw_init)
        begin
            wcnt_reg  <= WCW'(req_reg.char_cols);
            first_reg <= 1'b1;
            erase_reg <= 1'b0;
        end
        else if (cmd.erase_init)
        begin
            wcnt_reg  <= WCW'(cols_eff - CW'(cx_reg));
            first_reg <= 1'b1;
            erase_reg <= 1'b1;
        end
        else if (cmd.next)
        begin
            wcnt_reg  <= wcnt_reg - WCW'(1);
            first_reg <= 1'b0;
        end
    end

    // store walk
    logic [2:0]     wk_reg;
    logic [KW-1:0]  wn_reg;
    logic [RIW-1:0] wr_reg, wr_end_reg;
    logic [CIW-1:0] wc_reg, wc_start_reg, wc_end_reg;
    logic [KW-1:0]  amt_k, lim_k;
    logic           vert;

    assign vert  = (cmd.walk_kind == twce_pkg::WK_UP) || (cmd.walk_kind == twce_pkg::WK_DOWN);
    assign amt_k = KW'(req_reg.amount);
    assign lim_k = vert ? rows_k : cols_k;

    always_ff @(posedge clk)
    begin
        if (cmd.walk_start)
        begin
            wk_reg <= cmd.walk_kind;
            if (cmd.walk_one)
                wn_reg <= KW'(1);
            else
                wn_reg <= (amt_k > lim_k) ? lim_k : amt_k;
            case (cmd.walk_kind)
                twce_pkg::WK_DOWN:
                begin
                    wr_reg     <= cy_lastrow;
                    wr_end_reg <= '0;
                end
                twce_pkg::WK_LINE:
                begin
                    wr_reg     <= RIW'(req_reg.pos_row);
                    wr_end_reg <= RIW'(req_reg.pos_row);
                end
                default:
                begin
                    wr_reg     <= '0;
                    wr_end_reg <= cy_lastrow;
                end
            endcase
            if (cmd.walk_kind == twce_pkg::WK_RIGHT)
            begin
                wc_reg       <= cx_lastcol;
                wc_start_reg <= cx_lastcol;
                wc_end_reg   <= '0;
            end
            else
            begin
                wc_reg       <= '0;
                wc_start_reg <= '0;
                wc_end_reg   <= cx_lastcol;
            end
        end
        else if (cmd.walk_wr)
        begin
            if (wc_reg == wc_end_reg)
            begin
                wc_reg <= wc_start_reg;
                if (wk_reg == twce_pkg::WK_DOWN)
                    wr_reg <= wr_reg - RIW'(1);
                else
                    wr_reg <= wr_reg + RIW'(1);
            end
            else if (wk_reg == twce_pkg::WK_RIGHT)
                wc_reg <= wc_reg - CIW'(1);
            else
                wc_reg <= wc_reg + CIW'(1);
        end
    end

    // source cell of the current walk step
    logic [KW-1:0]  wr_k, wc_k;
    logic           w_copy;
    logic [RIW-1:0] src_row;
    logic [CIW-1:0] src_col;

    assign wr_k = KW'(wr_reg);
    assign wc_k = KW'(wc_reg);

    always_comb
    begin
        w_copy  = 1'b0;
        src_row = wr_reg;
        src_col = wc_reg;
        case (wk_reg)
            twce_pkg::WK_UP:
            begin
                w_copy  = (wr_k + wn_reg) < rows_k;
                src_row = RIW'(wr_k + wn_reg);
            end
            twce_pkg::WK_DOWN:
            begin
                w_copy  = wr_k >= wn_reg;
                src_row = RIW'(wr_k - wn_reg);
            end
            twce_pkg::WK_LEFT:
            begin
                w_copy  = (wc_k + wn_reg) < cols_k;
                src_col = CIW'(wc_k + wn_reg);
            end
            twce_pkg::WK_RIGHT:
            begin
                w_copy  = wc_k >= wn_reg;
                src_col = CIW'(wc_k - wn_reg);
            end
            default: w_copy = 1'b0;
        endcase
    end

    // cell store
    logic [47:0]    mem_q [CELLS];
    logic [47:0]    rdata_reg;
    logic [47:0]    wdata;
    logic [47:0]    blank_cell;
    logic [RIW-1:0] arow;
    logic [CIW-1:0] acol;
    logic [PW-1:0]  prod;
    logic [AW-1:0]  addr;
    logic           mem_we, mem_re;
    logic           col_ok, row_ok;

    assign col_ok     = KW'(req_reg.pos_col) < cols_k;
    assign row_ok     = KW'(req_reg.pos_row) < rows_k;
    assign blank_cell = {attrs_reg, 11'd0, blank_reg};

    always_comb
    begin
        if (cmd.walk_rd)
        begin
            arow = src_row;
            acol = src_col;
        end
        else if (cmd.walk_wr)
        begin
            arow = wr_reg;
            acol = wc_reg;
        end
        else if (cmd.peek_rd)
        begin
            arow = RIW'(req_reg.pos_row);
            acol = CIW'(req_reg.pos_col);
        end
        else
        begin
            arow = cy_reg;
            acol = cx_reg;
        end
        prod = PW'(arow) * PW'(cols_eff);
        addr = AW'(prod + PW'(acol));
    end

    always_comb
    begin
        if (cmd.walk_wr)
            wdata = w_copy ? rdata_reg : blank_cell;
        else if (erase_reg)
            wdata = blank_cell;
        else if (first_reg)
            wdata = {attrs_reg, 11'd0, req_reg.char_code};
        else
            wdata = {attrs_reg, twce_pkg::CONT_MARK};
    end

    assign mem_we = cmd.walk_wr || cmd.put;
    assign mem_re = cmd.walk_rd || (cmd.peek_rd && col_ok && row_ok);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_q[addr] <= wdata;
        if (mem_re)
            rdata_reg <= mem_q[addr];
    end

    // result
    logic                peek_hit_reg;
    logic                out_valid_reg;
    twce_pkg::out_item_t out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            peek_hit_reg <= 1'b0;
        else if (cmd.latch_req)
            peek_hit_reg <= 1'b0;
        else if (cmd.peek_rd)
            peek_hit_reg <= col_ok && row_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_item_reg.cell_code  <= peek_hit_reg ? rdata_reg[31:0] : 32'd0;
            out_item_reg.cell_attrs <= peek_hit_reg ? rdata_reg[47:32] : 16'd0;
            out_item_reg.cell_valid <= peek_hit_reg;
            out_item_reg.cursor_col <= 7'(cx_reg);
            out_item_reg.cursor_row <= 6'(cy_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // status
    always_comb
    begin
        stat.func        = req_reg.func;
        stat.is_tab      = req_reg.char_code == twce_pkg::CH_TAB;
        stat.is_eol      = (req_reg.char_code == twce_pkg::CH_CR)
                           || (req_reg.char_code == twce_pkg::CH_LF);
        stat.w_zero      = req_reg.char_cols == 3'd0;
        stat.fits        = (KW'(cx_reg) + KW'(req_reg.char_cols)) <= cols_k;
        stat.cx_last     = (KW'(cx_reg) + KW'(1)) >= cols_k;
        stat.cy_last     = (KW'(cy_reg) + KW'(1)) >= rows_k;
        stat.cx_zero     = cx_reg == '0;
        stat.cy_zero     = cy_reg == '0;
        stat.locked      = locked_reg;
        stat.col_ok      = col_ok;
        stat.row_ok      = row_ok;
        stat.amount_zero = req_reg.amount == 8'd0;
        stat.wcnt_one    = wcnt_reg == WCW'(1);
        stat.walk_last   = (wc_reg == wc_end_reg) && (wr_reg == wr_end_reg);
        stat.out_free    = !out_valid_reg || !out_stall;
    end

endmodule

@@ sv/text_window_cell_engine_core.sv @@
// ----------------------------------------------------------------------------
// text_window_cell_engine_core: character-cell text window engine
// Cursor-driven drawing, clearing, scrolling and peeking over a row-major
// store of code and attribute words.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------
//  in      | to core   | in_valid / in_stall   | in_item  (in_item_t)
//  out     | from core | out_valid / out_stall | out_item (out_item_t)
//  cfg     | to core   | cfg_wr_en             | cfg_index, cfg_data
//
//  One request at a time. Cursor moves and peeks pass through accept, clamp,
//  decode and result load; a line step (carriage return, step down) adds a
//  step-down state, and an emit of a w-column character a put and a next
//  state per column. Clears and scrolls walk the single-port cell store cell
//  by cell (read source, write destination): every cell for a full window,
//  one row for one line; a wrap that scrolls adds a full-window walk.
//  Reset zeroes the cursor and loads the default configuration; the store
//  holds nothing defined until cleared or written, and needs no clearing pass.
//  A result waits in the output register while out_stall is high; the next
//  request is taken as soon as the previous result is loaded.
//
module text_window_cell_engine_core #(
    parameter int MAX_COLS = twce_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = twce_pkg::MAX_ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [twce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [twce_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  twce_pkg::in_item_t              in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output twce_pkg::out_item_t             out_item
);

    twce_pkg::cmd_t    cmd;
    twce_pkg::status_t stat;

    // sequence each request through the datapath
    twce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // hold configuration, cursor, store and the result register
    twce_dpath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cmd       (cmd),
        .stat      (stat)
    );

    // a request in flight blocks the next one
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("request accepted while previous one in flight");

    // at most one store access per cycle
    a_one_store_access: assert property (
        @(posedge clk) disable iff (!rst_n)
        $countones({cmd.walk_rd, cmd.walk_wr, cmd.put, cmd.peek_rd}) <= 1
    ) else $error("conflicting store accesses");

    // never overwrite a result still waiting downstream
    a_no_result_overrun: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall)
    ) else $error("result loaded over a stalled result");

endmodule

@@ test/cell_engine_checker.sv @@
// ----------------------------------------------------------------------------
// cell_engine_checker: result checker for the text-window cell engine
// Watches the configuration port and the request and result channels, keeps its own
// copy of the cell store, cursor and registers, works out the expected
// result of every accepted request and compares each delivered result with
// the oldest expectation, field by field.
// ----------------------------------------------------------------------------
module cell_engine_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [twce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [twce_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  twce_pkg::in_item_t              in_item,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  twce_pkg::out_item_t             out_item,
    output int                              errors,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = twce_pkg::MAX_COLS_DEF * twce_pkg::MAX_ROWS_DEF;

    logic [31:0] cell_code_q [CELLS];
    logic [15:0] cell_attr_q [CELLS];
    int unsigned cur_x;
    int unsigned cur_y;

    logic [7:0]  win_cols;
    logic [6:0]  win_rows;
    logic [15:0] draw_attrs;
    logic [20:0] blank_code;
    logic        scroll_locked;

    twce_pkg::out_item_t expected_results[$];

    function automatic int unsigned cols_in_use();
        int unsigned c;
        c = 32'(win_cols);
        if (c < 1) c = 1;
        if (c > twce_pkg::MAX_COLS_DEF) c = twce_pkg::MAX_COLS_DEF;
        return c;
    endfunction

    function automatic int unsigned rows_in_use();
        int unsigned r;
        r = 32'(win_rows);
        if (r < 1) r = 1;
        if (r > twce_pkg::MAX_ROWS_DEF) r = twce_pkg::MAX_ROWS_DEF;
        return r;
    endfunction

    function automatic void put_cell(int unsigned col, int unsigned row, logic [31:0] code);
        int unsigned i;
        i = row * cols_in_use() + col;
        if (i < CELLS) begin
            cell_code_q[i] = code;
            cell_attr_q[i] = draw_attrs;
        end
    endfunction

    function automatic void blank_span(int unsigned row, int unsigned from, int unsigned to);
        for (int unsigned c = from; c < to; c++)
            put_cell(c, row, {11'd0, blank_code});
    endfunction

    function automatic void copy_row(int unsigned src, int unsigned dst);
        int unsigned cols;
        cols = cols_in_use();
        for (int unsigned c = 0; c < cols; c++) begin
            cell_code_q[dst * cols + c] = cell_code_q[src * cols + c];
            cell_attr_q[dst * cols + c] = cell_attr_q[src * cols + c];
        end
    endfunction

    function automatic void scroll_vertical(int unsigned n, bit up);
        int unsigned rows;
        int unsigned cols;
        rows = rows_in_use();
        cols = cols_in_use();
        if (n == 0) return;
        if (n > rows) n = rows;
        if (up) begin
            for (int unsigned i = 0; i + n < rows; i++) copy_row(i + n, i);
            for (int unsigned i = rows - n; i < rows; i++) blank_span(i, 0, cols);
        end else begin
            for (int unsigned i = rows; i > n; i--) copy_row(i - 1 - n, i - 1);
            for (int unsigned i = 0; i < n; i++) blank_span(i, 0, cols);
        end
    endfunction

    function automatic void scroll_horizontal(int unsigned n, bit left);
        int unsigned rows;
        int unsigned cols;
        int unsigned b;
        rows = rows_in_use();
        cols = cols_in_use();
        if (n == 0) return;
        if (n > cols) n = cols;
        for (int unsigned i = 0; i < rows; i++) begin
            b = i * cols;
            if (left) begin
                // ascending copy is safe when shifting toward column 0
                for (int unsigned c = 0; c + n < cols; c++) begin
                    cell_code_q[b + c] = cell_code_q[b + c + n];
                    cell_attr_q[b + c] = cell_attr_q[b + c + n];
                end
                blank_span(i, cols - n, cols);
            end else begin
                for (int unsigned c = cols; c > n; c--) begin
                    cell_code_q[b + c - 1] = cell_code_q[b + c - 1 - n];
                    cell_attr_q[b + c - 1] = cell_attr_q[b + c - 1 - n];
                end
                blank_span(i, 0, n);
            end
        end
    endfunction

    function automatic void step_down();
        if (cur_y + 1 < rows_in_use())
            cur_y++;
        else if (!scroll_locked)
            scroll_vertical(1, 1'b1);
    endfunction

    function automatic void step_right();
        if (cur_x + 1 < cols_in_use()) begin
            cur_x++;
        end else begin
            if (!scroll_locked) step_down();
            cur_x = 0;
        end
    endfunction

    function automatic void carriage_return();
        cur_x = 0;
        step_down();
    endfunction

    function automatic void draw_char(logic [31:0] code, int unsigned w);
        if (w == 0) return;
        if (cur_x + w > cols_in_use()) carriage_return();
        put_cell(cur_x, cur_y, code);
        step_right();
        for (int unsigned k = 1; k < w; k++) begin
            put_cell(cur_x, cur_y, twce_pkg::CONT_MARK);
            step_right();
        end
    endfunction

    function automatic twce_pkg::out_item_t predict_command(twce_pkg::in_item_t it);
        twce_pkg::out_item_t r;
        int unsigned cols;
        int unsigned rows;
        int unsigned pc;
        int unsigned pr;
        int unsigned i;
        cols = cols_in_use();
        rows = rows_in_use();
        pc   = 32'(it.pos_col);
        pr   = 32'(it.pos_row);
        r = '0;
        // clamp a cursor left outside by a size change
        if (cur_x >= cols) cur_x = cols - 1;
        if (cur_y >= rows) cur_y = rows - 1;
        case (it.func)
            twce_pkg::FN_EMIT: begin
                if (it.char_code == twce_pkg::CH_CR || it.char_code == twce_pkg::CH_LF)
                    carriage_return();
                else if (it.char_code != twce_pkg::CH_TAB)
                    draw_char({11'd0, it.char_code}, 32'(it.char_cols));
            end
            twce_pkg::FN_CR: carriage_return();
            twce_pkg::FN_CLEAR: begin
                for (int unsigned row = 0; row < rows; row++) blank_span(row, 0, cols);
                cur_x = 0;
                cur_y = 0;
            end
            twce_pkg::FN_CLEAR_LINE: if (pr < rows) blank_span(pr, 0, cols);
            twce_pkg::FN_SCROLL_UP: scroll_vertical(32'(it.amount), 1'b1);
            twce_pkg::FN_SCROLL_DOWN: scroll_vertical(32'(it.amount), 1'b0);
            twce_pkg::FN_SCROLL_LEFT: scroll_horizontal(32'(it.amount), 1'b1);
            twce_pkg::FN_SCROLL_RIGHT: scroll_horizontal(32'(it.amount), 1'b0);
            twce_pkg::FN_SET_XY: begin
                if (pc < cols && pr < rows) begin
                    cur_x = pc;
                    cur_y = pr;
                end
            end
            twce_pkg::FN_SET_X: if (pc < cols) cur_x = pc;
            twce_pkg::FN_SET_Y: if (pr < rows) cur_y = pr;
            twce_pkg::FN_STEP_UP: if (cur_y != 0) cur_y--;
            twce_pkg::FN_STEP_DOWN: step_down();
            twce_pkg::FN_STEP_LEFT: begin
                if (cur_x != 0) begin
                    cur_x--;
                end else if (cur_y != 0) begin
                    cur_y--;
                    cur_x = cols - 1;
                end
            end
            twce_pkg::FN_STEP_RIGHT: step_right();
            twce_pkg::FN_PEEK: begin
                if (pc < cols && pr < rows) begin
                    i = pr * cols + pc;
                    if (i < CELLS) begin
                        r.cell_code  = cell_code_q[i];
                        r.cell_attrs = cell_attr_q[i];
                        r.cell_valid = 1'b1;
                    end
                end
            end
            twce_pkg::FN_ERASE_EOL: begin
                // blank code goes in as a plain one-column character
                do
                    draw_char({11'd0, blank_code}, 1);
                while (cur_x != 0);
            end
            default: ;
        endcase
        r.cursor_col = cur_x[6:0];
        r.cursor_row = cur_y[5:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    initial errors = 0;

    always @(posedge clk or negedge rst_n) begin
        twce_pkg::out_item_t exp_r;
        if (!rst_n) begin
            cur_x         = 0;
            cur_y         = 0;
            win_cols      = twce_pkg::COLS_RST;
            win_rows      = twce_pkg::ROWS_RST;
            draw_attrs    = twce_pkg::ATTRS_RST;
            blank_code    = twce_pkg::BLANK_RST;
            scroll_locked = 1'b0;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    twce_pkg::CFG_COLS:   win_cols      = cfg_data[7:0];
                    twce_pkg::CFG_ROWS:   win_rows      = cfg_data[6:0];
                    twce_pkg::CFG_ATTRS:  draw_attrs    = cfg_data[15:0];
                    twce_pkg::CFG_BLANK:  blank_code    = cfg_data[20:0];
                    twce_pkg::CFG_LOCKED: scroll_locked = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result delivered with no request outstanding");
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("cell_code", exp_r.cell_code, out_item.cell_code);
                    check_field("cell_attrs", 32'(exp_r.cell_attrs), 32'(out_item.cell_attrs));
                    check_field("cell_valid", 32'(exp_r.cell_valid), 32'(out_item.cell_valid));
                    check_field("cursor_col", 32'(exp_r.cursor_col), 32'(out_item.cursor_col));
                    check_field("cursor_row", 32'(exp_r.cursor_row), 32'(out_item.cursor_row));
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(predict_command(in_item));
        end
        pending = expected_results.size();
    end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: top-level testbench of the text-window cell engine
// Drives configuration phases and command requests (a directed opening,
// then weighted random traffic), toggles sender and receiver pressure, and
// reports the verdict from the failure count of the result checker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no handshake on either channel before giving up;
    // covers a full 128x64 walk per column step of a 7-column wrap
    localparam int QUIET_LIMIT = 400000;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [twce_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [twce_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    twce_pkg::in_item_t              in_item;
    logic                            out_valid;
    logic                            out_stall;
    twce_pkg::out_item_t             out_item;

    int errors;
    int pending;
    int requests_sent;
    int sender_idle_pct;
    int receiver_stall_pct;
    int quiet_cycles;
    int unsigned view_cols;     // window size in use, for aiming positions
    int unsigned view_rows;

    text_window_cell_engine_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    cell_engine_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .errors    (errors),
        .pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: stall at random with the current pressure.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < receiver_stall_pct);

    // Watchdog: count cycles with no request or result moving.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic twce_pkg::in_item_t make_cmd(logic [4:0] func, logic [20:0] code,
                                                    logic [2:0] w, logic [7:0] amount,
                                                    logic [6:0] pc, logic [5:0] pr);
        twce_pkg::in_item_t it;
        it.func      = func;
        it.char_code = code;
        it.char_cols = w;
        it.amount    = amount;
        it.pos_col   = pc;
        it.pos_row   = pr;
        return it;
    endfunction

    // Weighted random command: mostly drawing and cursor traffic, with
    // walks (clears, scrolls) kept rare on large windows.
    function automatic twce_pkg::in_item_t random_cmd();
        twce_pkg::in_item_t it;
        int       sel;
        int       walk_pct;
        it = twce_pkg::in_item_t'($bits(twce_pkg::in_item_t)'({$urandom(), $urandom()}));
        walk_pct = (view_cols * view_rows > 2000) ? 1 : 8;
        sel = $urandom_range(99);
        if (sel < walk_pct) begin
            it.func = twce_pkg::FN_CLEAR + 5'($urandom_range(5));
            if ($urandom_range(3) != 0) it.amount = 8'($urandom_range(3));
            if ($urandom_range(3) != 0) it.pos_row = 6'($urandom_range(view_rows - 1));
        end else if (sel < 50) begin
            it.func = twce_pkg::FN_EMIT;
            case ($urandom_range(19))
                0: it.char_code = twce_pkg::CH_TAB;
                1: it.char_code = twce_pkg::CH_CR;
                2: it.char_code = twce_pkg::CH_LF;
                3, 4, 5: ;  // keep the full-range random code
                default: it.char_code = 21'h20 + 21'($urandom_range(94));
            endcase
            if ($urandom_range(9) < 6) it.char_cols = 3'd1;
        end else if (sel < 88) begin
            it.func = (sel < 72) ? twce_pkg::FN_SET_XY + 5'($urandom_range(6))
                                 : twce_pkg::FN_PEEK;
            // aim most positions inside the window
            if ($urandom_range(4) != 0) begin
                it.pos_col = 7'($urandom_range(view_cols - 1));
                it.pos_row = 6'($urandom_range(view_rows - 1));
            end
        end else if (sel < 93) begin
            it.func = twce_pkg::FN_ERASE_EOL;
        end else if (sel < 96) begin
            it.func = twce_pkg::FN_CR;
        end else begin
            it.func = 5'($urandom_range(31, 17));
        end
        return it;
    endfunction

    task automatic send_request(twce_pkg::in_item_t it);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        requests_sent++;
        // pressure schedule: sender-light, then receiver-light, then none
        if (requests_sent < 600) begin
            sender_idle_pct    = 21;
            receiver_stall_pct = 67;
        end else if (requests_sent < 1200) begin
            sender_idle_pct    = 67;
            receiver_stall_pct = 21;
        end else begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
        end
    endtask

    // Hold off new requests until every result is back and the core is quiet.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(logic [twce_pkg::CFG_IDX_W-1:0] idx,
                             logic [twce_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Reprogram every register on an idle core, then clear the window so
    // every peekable cell holds a defined value.
    task automatic setup_window(int cols, int rows, int attrs, int blank, int locked);
        wait_idle();
        cfg_write(twce_pkg::CFG_COLS, twce_pkg::CFG_DATA_W'(cols));
        cfg_write(twce_pkg::CFG_ROWS, twce_pkg::CFG_DATA_W'(rows));
        cfg_write(twce_pkg::CFG_ATTRS, twce_pkg::CFG_DATA_W'(attrs));
        cfg_write(twce_pkg::CFG_BLANK, twce_pkg::CFG_DATA_W'(blank));
        cfg_write(twce_pkg::CFG_LOCKED, twce_pkg::CFG_DATA_W'(locked));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        view_cols = 32'(cols[7:0]);
        if (view_cols < 1) view_cols = 1;
        if (view_cols > twce_pkg::MAX_COLS_DEF) view_cols = twce_pkg::MAX_COLS_DEF;
        view_rows = 32'(rows[6:0]);
        if (view_rows < 1) view_rows = 1;
        if (view_rows > twce_pkg::MAX_ROWS_DEF) view_rows = twce_pkg::MAX_ROWS_DEF;
        send_request(make_cmd(twce_pkg::FN_CLEAR, '0, '0, '0, '0, '0));
    endtask

    task automatic random_phase(int cols, int rows, int attrs, int blank, int locked, int count);
        setup_window(cols, rows, attrs, blank, locked);
        for (int k = 0; k < count; k++) begin
            send_request(random_cmd());
            // drain the pipe now and then with the sender held off
            if (k % 97 == 96) wait_idle();
        end
    endtask

    initial begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        in_valid           = 1'b0;
        in_item            = '0;
        out_stall          = 1'b0;
        quiet_cycles       = 0;
        requests_sent      = 0;
        sender_idle_pct    = 21;
        receiver_stall_pct = 67;
        view_cols          = 80;
        view_rows          = 24;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening on a narrow 5x3 window.
        setup_window(5, 3, 'hA5A5, 'h1FFFFF, 0);
        send_request(make_cmd(twce_pkg::FN_EMIT, 21'h41, 3'd1, '0, '0, '0));
        send_request(make_cmd(twce_pkg::FN_EMIT, 21'h4E2D, 3'd2, '0, '0, '0));
        send_request(make_cmd(twce_pkg::FN_EMIT, twce_pkg::CH_TAB, 3'd1, '0, '0, '0));
        send_request(make_cmd(twce_pkg::FN_EMIT, 21'h42, 3'd0, '0, '0, '0));
        send_request(make_cmd(twce_pkg::FN_EMIT, twce_pkg::CH_CR, 3'd1, '0, '0, '0));
        send_request(make_cmd(twce_pkg::FN_EMIT, twce_pkg::CH_LF, 3'd1, '0, '0, '0));
        // wider than the window: wraps and scrolls while drawing markers
        send_request(make_cmd(twce_pkg::FN_EMIT, 21'h1FFFFF, 3'd7, '0, '0, '0));
        send_request(make_cmd(twce_pkg::FN_SET_XY, '0, '0, '0, 7'd4, 6'd2));
        send_request(make_cmd(twce_pkg::FN_EMIT, 21'h3042, 3'd2, '0, '0, '0));
        send_request(make_cmd(twce_pkg::FN_SET_XY, '0, '0, '0, 7'd4, 6'd2));
        send_request(make_cmd(twce_pkg::FN_STEP_RIGHT, '0, '0, '0, '0, '0));
        send_request(make_cmd(twce_pkg::FN_STEP_DOWN, '0, '0, '0, '0, '0));
        send_request(make_cmd(twce_pkg::FN_SET_XY, '0, '0, '0, 7'd127, 6'd63));
        send_request(make_cmd(twce_pkg::FN_SET_X, '0, '0, '0, 7'd0, '0));
        send_request(make_cmd(twce_pkg::FN_STEP_LEFT, '0, '0, '0, '0, '0));
        send_request(make_cmd(twce_pkg::FN_SET_Y, '0, '0, '0, '0, 6'd0));
        send_request(make_cmd(twce_pkg::FN_STEP_LEFT, '0, '0, '0, '0, '0));
        send_request(make_cmd(twce_pkg::FN_STEP_UP, '0, '0, '0, '0, '0));
        send_request(make_cmd(twce_pkg::FN_CLEAR_LINE, '0, '0, '0, '0, 6'd1));
        send_request(make_cmd(twce_pkg::FN_CLEAR_LINE, '0, '0, '0, '0, 6'd63));
        send_request(make_cmd(twce_pkg::FN_SCROLL_UP, '0, '0, 8'd1, '0, '0));
        send_request(make_cmd(twce_pkg::FN_SCROLL_DOWN, '0, '0, 8'd255, '0, '0));
        send_request(make_cmd(twce_pkg::FN_SCROLL_LEFT, '0, '0, 8'd2, '0, '0));
        send_request(make_cmd(twce_pkg::FN_SCROLL_RIGHT, '0, '0, 8'd0, '0, '0));
        send_request(make_cmd(twce_pkg::FN_PEEK, '0, '0, '0, 7'd0, 6'd0));
        send_request(make_cmd(twce_pkg::FN_PEEK, '0, '0, '0, 7'd127, 6'd63));
        send_request(make_cmd(twce_pkg::FN_ERASE_EOL, '0, '0, '0, '0, '0));
        send_request(make_cmd(5'd31, 21'h1FFFFF, 3'd7, 8'd255, 7'd127, 6'd63));

        // Random phases; out-of-range sizes saturate, big windows stay short.
        random_phase(12, 5, 'h0000, 'h000020, 0, 300);
        random_phase(7, 3, 'hFFFF, 'h00000A, 1, 200);
        random_phase(1, 1, 'h1234, 'h000009, 0, 80);
        random_phase(0, 0, 'h8001, 'h000000, 1, 60);
        random_phase(128, 2, 'h5A5A, 'h1FFFFF, 0, 60);
        random_phase(3, 64, 'hC3C3, 'h00000D, 0, 60);
        random_phase(255, 127, 'h7FFF, 'h10FFFF, 0, 15);
        random_phase(20, 10, 'h0F0F, 'h0000A0, 1, 300);
        random_phase(5, 6, 'hF0F0, 'h0AAAAA, 0, 300);
        random_phase(16, 8, 'h3C3C, 'h155555, 0, 300);

        wait_idle();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
sv/twce_pkg.sv
sv/twce_ctrl.sv
sv/twce_dpath.sv
sv/text_window_cell_engine_core.sv
test/cell_engine_checker.sv
test/tb.sv
